### rtl/rtc_fields_to_unix_seconds_defines.svh
// assertion macros shared by the rtc-to-unix-seconds rtl
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef RTC_FIELDS_TO_UNIX_SECONDS_DEFINES_SVH
`define RTC_FIELDS_TO_UNIX_SECONDS_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RFU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RFU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rfu_pkg.sv
// constants, types and small helper functions for the rtc-to-unix-seconds block
// no dependencies
package rfu_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CENTURY_PRESENT = 1'b0;
    localparam t_cfg_idx CFG_BASE_YEAR       = 1'b1;

    localparam int BASE_YEAR_W = 14;
    localparam logic [BASE_YEAR_W-1:0] BASE_YEAR_RST = 14'd2018;
    localparam logic [7:0] BASE_HUND_RST = 8'd20;

    // status b bits and the pm flag bit of the hour byte
    localparam int SB_BINARY = 2;
    localparam int SB_24HOUR = 1;
    localparam int HOUR_PM   = 7;

    localparam int SECONDS_W = 41;
    localparam int STAGES    = 6;

    // days from 0000-03-01 style count to the epoch
    localparam logic signed [25:0] EPOCH_DAYS  = 26'sd719561;
    localparam logic signed [40:0] SEC_PER_DAY = 41'sd86400;

    // reciprocal of 100, exact for values below 43690
    localparam int RECIP100_SHIFT = 19;
    localparam logic [12:0] RECIP100 = 13'd5243;

    typedef logic [7:0] t_byte;

    function automatic t_byte bcd_decode(input t_byte b);
        t_byte tens;
        tens = {4'd0, b[7:4]};
        return 8'({4'd0, b[3:0]}) + 8'((tens << 3) + (tens << 1));
    endfunction

    // x mod 24 for x below 192
    function automatic t_byte mod24(input t_byte x);
        t_byte v;
        v = x;
        if (v >= 8'd96) begin
            v = v - 8'd96;
        end
        if (v >= 8'd48) begin
            v = v - 8'd48;
        end
        if (v >= 8'd24) begin
            v = v - 8'd24;
        end
        return v;
    endfunction

endpackage

### rtl/rtc_fields_to_unix_seconds.sv
// rtc snapshot to unix seconds: six-stage pipeline, single module
// depends on rfu_pkg and rtc_fields_to_unix_seconds_defines.svh
//
// Converts one snapshot of raw cmos rtc bytes plus status b into signed 41-bit
// seconds since 1970-01-01 00:00. Bytes are bcd unless status b bit 2 is set; a
// pm hour (bit 7) is folded to 24-hour form unless status b bit 1 is set. The
// full year comes from the century byte when century_present is 1, else from
// base_year with a 100-year rollover. Invalid bcd and out-of-range fields are
// not checked; they add into the count as they decode. A year that falls below
// zero (year 0, january or february) gives a negative result. Throughput is one
// item per clock with no stall on the output; each item goes in turn through the
// pipeline stages (decode, year/month terms, leap-day quotients, day sum,
// day multiply, final add). Each stage holds its item while the stage after it
// is full and stalled, so the input is stalled only when all six stages hold an
// item and the output is stalled. Configuration writes are taken every cycle
// (ready is tied high) and must be made only while the pipeline is empty.
module rtc_fields_to_unix_seconds (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_raw_second,
    input  logic [7:0]                          i_raw_minute,
    input  logic [7:0]                          i_raw_hour,
    input  logic [7:0]                          i_raw_day,
    input  logic [7:0]                          i_raw_month,
    input  logic [7:0]                          i_raw_year,
    input  logic [7:0]                          i_raw_century,
    input  logic [7:0]                          i_status_b,
    // result item channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [rfu_pkg::SECONDS_W-1:0] o_unix_seconds,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  rfu_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [rfu_pkg::BASE_YEAR_W-1:0]     i_cfg_data
);

    `include "rtc_fields_to_unix_seconds_defines.svh"

    localparam int NS = rfu_pkg::STAGES;

    // ------------------------------------------------------------------
    // configuration registers
    // base year / 100 is kept alongside base year so the pipeline never divides
    logic                              r_century_present;
    logic [rfu_pkg::BASE_YEAR_W-1:0]   r_base_year;
    logic [7:0]                        r_base_hund;
    logic [26:0]                       w_cfg_hund_prod;

    assign o_cfg_ready     = 1'b1;
    assign w_cfg_hund_prod = 27'(i_cfg_data) * 27'(rfu_pkg::RECIP100);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_century_present <= 1'b0;
            r_base_year       <= rfu_pkg::BASE_YEAR_RST;
            r_base_hund       <= rfu_pkg::BASE_HUND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rfu_pkg::CFG_CENTURY_PRESENT: begin
                    r_century_present <= i_cfg_data[0];
                end
                rfu_pkg::CFG_BASE_YEAR: begin
                    r_base_year <= i_cfg_data;
                    r_base_hund <= w_cfg_hund_prod[26:rfu_pkg::RECIP100_SHIFT];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline flow control: a stage may load when it is empty or the next
    // stage loads in the same cycle
    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;
    logic [NS-1:0] w_v_in;

    always_comb begin
        w_rdy[NS] = !i_out_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
        w_v_in[0] = i_in_valid;
        for (int k = 1; k < NS; k++) begin
            w_v_in[k] = r_v[k-1];
        end
    end

    assign o_in_stall  = !w_rdy[0];
    assign o_out_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= w_v_in[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: bcd decode, 12-hour fold, month shift, year base
    logic        w_bin;
    logic [7:0]  w_sec, w_min, w_day, w_mon, w_yr, w_cent, w_hour_dec;
    logic [6:0]  w_hour_bcd;
    logic [7:0]  n1_sec, n1_min, n1_hour, n1_day, n1_mon, n1_yr;
    logic        n1_jf;
    logic [14:0] n1_ybase;
    logic [7:0]  r1_sec, r1_min, r1_hour, r1_day, r1_mon, r1_yr;
    logic        r1_jf;
    logic [14:0] r1_ybase;

    always_comb begin
        w_bin      = i_status_b[rfu_pkg::SB_BINARY];
        w_sec      = w_bin ? i_raw_second  : rfu_pkg::bcd_decode(i_raw_second);
        w_min      = w_bin ? i_raw_minute  : rfu_pkg::bcd_decode(i_raw_minute);
        w_day      = w_bin ? i_raw_day     : rfu_pkg::bcd_decode(i_raw_day);
        w_mon      = w_bin ? i_raw_month   : rfu_pkg::bcd_decode(i_raw_month);
        w_yr       = w_bin ? i_raw_year    : rfu_pkg::bcd_decode(i_raw_year);
        w_cent     = w_bin ? i_raw_century : rfu_pkg::bcd_decode(i_raw_century);
        // hour tens digit is bits 6..4 only, pm flag rides along in bit 7
        w_hour_bcd = 7'({4'd0, i_raw_hour[3:0]})
                   + 7'(({4'd0, i_raw_hour[6:4]} << 3) + ({4'd0, i_raw_hour[6:4]} << 1));
        w_hour_dec = w_bin ? i_raw_hour : {i_raw_hour[rfu_pkg::HOUR_PM], w_hour_bcd};

        n1_sec = w_sec;
        n1_min = w_min;
        n1_day = w_day;
        n1_yr  = w_yr;
        if (!i_status_b[rfu_pkg::SB_24HOUR] && w_hour_dec[rfu_pkg::HOUR_PM]) begin
            n1_hour = rfu_pkg::mod24(8'({1'b0, w_hour_dec[6:0]}) + 8'd12);
        end else begin
            n1_hour = w_hour_dec;
        end
        // january and february count as months 13 and 14 of the year before
        n1_jf  = (w_mon <= 8'd2);
        n1_mon = n1_jf ? w_mon + 8'd12 : w_mon;
        if (r_century_present) begin
            n1_ybase = 15'(w_cent) * 15'd100;
        end else begin
            n1_ybase = 15'(r_base_hund) * 15'd100;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_sec   <= n1_sec;
            r1_min   <= n1_min;
            r1_hour  <= n1_hour;
            r1_day   <= n1_day;
            r1_mon   <= n1_mon;
            r1_yr    <= n1_yr;
            r1_jf    <= n1_jf;
            r1_ybase <= n1_ybase;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: full year, day-of-year term, time-of-day seconds
    logic [15:0]        w_ysum, w_yadj;
    logic [9:0]         w_mon3;
    logic [17:0]        w_mon_div_prod;
    logic signed [15:0] n2_year;
    logic [13:0]        n2_mterm;
    logic [19:0]        n2_hms;
    logic signed [15:0] r2_year;
    logic [13:0]        r2_mterm;
    logic [19:0]        r2_hms;

    always_comb begin
        w_ysum = 16'(r1_ybase) + 16'(r1_yr);
        if (!r_century_present && (w_ysum < 16'(r_base_year))) begin
            w_yadj = w_ysum + 16'd100;
        end else begin
            w_yadj = w_ysum;
        end
        // year 0 in january or february goes to -1
        n2_year = signed'(w_yadj - 16'(r1_jf));

        // (3 * (mon + 1)) / 5 through a reciprocal, exact below 1024
        w_mon3         = 10'(r1_mon) * 10'd3 + 10'd3;
        w_mon_div_prod = 18'(w_mon3) * 18'd205;
        n2_mterm       = 14'(r1_mon) * 14'd30 + 14'(w_mon_div_prod[17:10]) + 14'(r1_day);

        n2_hms = 20'(r1_hour) * 20'd3600 + 20'(r1_min) * 20'd60 + 20'(r1_sec);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r2_year  <= n2_year;
            r2_mterm <= n2_mterm;
            r2_hms   <= n2_hms;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: 365 * year, floor quotients by 4 and 100
    logic [27:0]        w_q100_prod;
    logic signed [24:0] n3_y365;
    logic signed [15:0] n3_y4;
    logic signed [9:0]  n3_q100;
    logic signed [24:0] r3_y365;
    logic signed [15:0] r3_y4;
    logic signed [9:0]  r3_q100;
    logic [13:0]        r3_mterm;
    logic [19:0]        r3_hms;

    always_comb begin
        n3_y365     = 25'(r2_year) * 25'sd365;
        n3_y4       = r2_year >>> 2;
        w_q100_prod = 28'(r2_year[14:0]) * 28'(rfu_pkg::RECIP100);
        // the only negative year is -1, whose floor quotient is -1
        if (r2_year < 0) begin
            n3_q100 = -10'sd1;
        end else begin
            n3_q100 = signed'({1'b0, w_q100_prod[27:rfu_pkg::RECIP100_SHIFT]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r3_y365  <= n3_y365;
            r3_y4    <= n3_y4;
            r3_q100  <= n3_q100;
            r3_mterm <= r2_mterm;
            r3_hms   <= r2_hms;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: day count relative to the epoch
    logic signed [25:0] n4_days;
    logic signed [25:0] r4_days;
    logic [19:0]        r4_hms;

    always_comb begin
        n4_days = 26'(r3_y365) + 26'(r3_y4) - 26'(r3_q100) + 26'(r3_q100 >>> 2)
                + signed'({12'd0, r3_mterm}) - rfu_pkg::EPOCH_DAYS;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r4_days <= n4_days;
            r4_hms  <= r3_hms;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: days to seconds
    logic signed [rfu_pkg::SECONDS_W-1:0] n5_prod;
    logic signed [rfu_pkg::SECONDS_W-1:0] r5_prod;
    logic [19:0]                          r5_hms;

    assign n5_prod = rfu_pkg::SECONDS_W'(r4_days) * rfu_pkg::SEC_PER_DAY;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r5_prod <= n5_prod;
            r5_hms  <= r4_hms;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: add time of day, output register
    logic signed [rfu_pkg::SECONDS_W-1:0] n6_secs;
    logic signed [rfu_pkg::SECONDS_W-1:0] r6_secs;

    assign n6_secs = r5_prod + signed'({(rfu_pkg::SECONDS_W - 20)'(0), r5_hms});

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r6_secs <= n6_secs;
        end
    end

    assign o_unix_seconds = r6_secs;

    // ------------------------------------------------------------------
    // checks

    `RFU_ASSERT_IMPL(a_stall_only_when_full, o_in_stall, ((&r_v) && i_out_stall), "input stalled with room in the pipeline")

    `RFU_ASSERT_NEXT(a_no_item_created, !(i_in_valid && !o_in_stall), ($countones(r_v) <= $past($countones(r_v))), "item count grew without an accepted item")

    `RFU_ASSERT_IMPL(a_month_shifted, r_v[0], (r1_mon >= 8'd3), "stage 1 month below march after shift")

    `RFU_ASSERT_IMPL(a_base_hund_match, 1'b1, ((15'(r_base_hund) * 15'd100 <= 15'(r_base_year)) && (15'(r_base_year) < 15'(r_base_hund) * 15'd100 + 15'd100)), "base year hundreds out of step with base year")

endmodule

### dv/rtc_fields_to_unix_seconds_checker.sv
// result checker for the rtc-to-unix-seconds block: watches the config, input and result channels
// depends on rfu_pkg for the register indexes, status b bit positions and field widths
`timescale 1ns / 1ps

module rtc_fields_to_unix_seconds_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_stall,
    input  logic [7:0]                            i_raw_second,
    input  logic [7:0]                            i_raw_minute,
    input  logic [7:0]                            i_raw_hour,
    input  logic [7:0]                            i_raw_day,
    input  logic [7:0]                            i_raw_month,
    input  logic [7:0]                            i_raw_year,
    input  logic [7:0]                            i_raw_century,
    input  logic [7:0]                            i_status_b,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_stall,
    input  logic signed [rfu_pkg::SECONDS_W-1:0]  i_unix_seconds,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  rfu_pkg::t_cfg_idx                     i_cfg_index,
    input  logic [rfu_pkg::BASE_YEAR_W-1:0]       i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_pending
);

    logic                                  century_used;
    logic [rfu_pkg::BASE_YEAR_W-1:0]       base_year;
    logic signed [rfu_pkg::SECONDS_W-1:0]  expected_seconds [$];
    int                                    fails;

    function automatic longint floor_quot(input longint a, input longint d);
        if (a >= 0) begin
            return a / d;
        end
        return -((-a + d - 1) / d);
    endfunction

    function automatic longint bcd_value(input logic [7:0] b);
        return longint'(b[3:0]) + 10 * longint'(b[7:4]);
    endfunction

    function automatic logic signed [rfu_pkg::SECONDS_W-1:0] unix_seconds_of(
        input logic [7:0] sec_b, input logic [7:0] min_b, input logic [7:0] hour_b,
        input logic [7:0] day_b, input logic [7:0] mon_b, input logic [7:0] year_b,
        input logic [7:0] cent_b, input logic [7:0] sb,
        input logic use_century, input logic [rfu_pkg::BASE_YEAR_W-1:0] ref_year
    );
        longint sec, mins, hour, day, mon, year, cent, base, days, total;
        sec  = longint'(sec_b);
        mins = longint'(min_b);
        hour = longint'(hour_b);
        day  = longint'(day_b);
        mon  = longint'(mon_b);
        year = longint'(year_b);
        cent = longint'(cent_b);
        base = longint'(ref_year);
        if (!sb[rfu_pkg::SB_BINARY]) begin
            sec  = bcd_value(sec_b);
            mins = bcd_value(min_b);
            // hour tens digit is bits 6..4 only, pm flag carried through
            hour = longint'(hour_b[3:0]) + 10 * longint'(hour_b[6:4])
                 + (hour_b[rfu_pkg::HOUR_PM] ? 128 : 0);
            day  = bcd_value(day_b);
            mon  = bcd_value(mon_b);
            year = bcd_value(year_b);
            cent = bcd_value(cent_b);
        end
        if (!sb[rfu_pkg::SB_24HOUR] && hour[rfu_pkg::HOUR_PM]) begin
            hour = ((hour & 'h7F) + 12) % 24;
        end
        if (use_century) begin
            year = year + cent * 100;
        end else begin
            year = year + (base / 100) * 100;
            if (year < base) begin
                year = year + 100;
            end
        end
        // january and february count as months 13 and 14 of the year before
        if (mon <= 2) begin
            mon  = mon + 12;
            year = year - 1;
        end
        days = 365 * year + floor_quot(year, 4) - floor_quot(year, 100)
             + floor_quot(year, 400);
        days = days + 30 * mon + (3 * (mon + 1)) / 5 + day;
        days = days - longint'(rfu_pkg::EPOCH_DAYS);
        total = days * longint'(rfu_pkg::SEC_PER_DAY) + 3600 * hour + 60 * mins + sec;
        return total[rfu_pkg::SECONDS_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic signed [rfu_pkg::SECONDS_W-1:0] want;
        if (!i_rst_n) begin
            century_used = 1'b0;
            base_year    = rfu_pkg::BASE_YEAR_RST;
            expected_seconds.delete();
            fails        = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    rfu_pkg::CFG_CENTURY_PRESENT: century_used = i_cfg_data[0];
                    rfu_pkg::CFG_BASE_YEAR:       base_year    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_seconds.push_back(unix_seconds_of(
                    i_raw_second, i_raw_minute, i_raw_hour, i_raw_day, i_raw_month,
                    i_raw_year, i_raw_century, i_status_b, century_used, base_year));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_seconds.size() == 0) begin
                    $display("%0t: unexpected result item, actual %0d", $time,
                             i_unix_seconds);
                    fails = fails + 1;
                end else begin
                    want = expected_seconds.pop_front();
                    if (i_unix_seconds !== want) begin
                        $display("%0t: unix_seconds mismatch, expected %0d actual %0d",
                                 $time, want, i_unix_seconds);
                        fails = fails + 1;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_seconds.size();
    end

endmodule

### dv/rtc_fields_to_unix_seconds_tb.sv
// testbench top for rtc_fields_to_unix_seconds: directed and random snapshots under
// several register settings, results checked by rtc_fields_to_unix_seconds_checker
`timescale 1ns / 1ps

module rtc_fields_to_unix_seconds_tb;

    localparam int     ITEMS_PER_PHASE = 200;
    localparam int     RANDOM_PHASES   = 8;
    // far above the slowest legal run (~1700 items, heavy stalls, a few drains)
    localparam longint WATCHDOG_NS     = 2_000_000;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_in_valid;
    logic                                 o_in_stall;
    logic [7:0]                           i_raw_second;
    logic [7:0]                           i_raw_minute;
    logic [7:0]                           i_raw_hour;
    logic [7:0]                           i_raw_day;
    logic [7:0]                           i_raw_month;
    logic [7:0]                           i_raw_year;
    logic [7:0]                           i_raw_century;
    logic [7:0]                           i_status_b;
    logic                                 o_out_valid;
    logic                                 i_out_stall;
    logic signed [rfu_pkg::SECONDS_W-1:0] o_unix_seconds;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    rfu_pkg::t_cfg_idx                    i_cfg_index;
    logic [rfu_pkg::BASE_YEAR_W-1:0]      i_cfg_data;

    int fail_count;
    int pending;
    int send_gap_pct;
    int recv_stall_pct;

    // snapshots packed as {second, minute, hour, day, month, year, century, status b}
    // sent with the register reset values (no century byte, base year 2018)
    logic [63:0] snapshots_reset_cfg [12] = '{
        64'h00_00_00_00_00_00_00_00,   // all zero: month 0 and year rollover to 2100
        64'hFF_FF_FF_FF_FF_FF_FF_FF,   // all ones: binary, 24-hour, hour 255
        64'hFF_FF_FF_FF_FF_FF_FF_00,   // invalid bcd digits everywhere, pm flag
        64'h56_34_12_29_02_24_00_02,   // leap day in bcd, 24-hour
        64'h00_00_92_01_01_18_00_00,   // 12 pm folds to hour 0, year equals base
        64'h59_59_81_31_12_17_00_00,   // 1 pm, year 17 rolls over to 2117
        64'h00_00_85_15_06_99_00_02,   // 24-hour with bit 7 set adds 128 hours
        64'h3B_3B_8B_1F_0C_63_00_04,   // binary 12-hour pm 11
        64'hC8_C8_17_64_32_FF_00_06,   // binary values beyond calendar range
        64'h00_00_11_01_01_00_00_00,   // 11 am in january
        64'h05_09_23_09_10_50_00_7F,   // noise bits in status b around binary/24h
        64'h00_00_00_00_00_00_00_F9    // noise bits in status b, bcd 12-hour
    };

    // sent with the century byte in use
    logic [63:0] snapshots_century [7] = '{
        64'h00_00_00_01_01_00_00_02,   // year 0 january goes below zero
        64'h59_59_23_29_02_00_00_02,   // year 0 february
        64'h00_00_00_00_00_00_00_00,   // year 0 month 0
        64'h00_00_00_01_01_70_19_02,   // the epoch itself
        64'hFF_FF_FF_FF_FF_FF_FF_06,   // binary maximum in every field
        64'h59_59_23_31_12_99_99_02,   // last second of year 9999
        64'h99_99_99_99_99_99_FF_00    // invalid bcd century
    };

    rtc_fields_to_unix_seconds dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_raw_second   (i_raw_second),
        .i_raw_minute   (i_raw_minute),
        .i_raw_hour     (i_raw_hour),
        .i_raw_day      (i_raw_day),
        .i_raw_month    (i_raw_month),
        .i_raw_year     (i_raw_year),
        .i_raw_century  (i_raw_century),
        .i_status_b     (i_status_b),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_unix_seconds (o_unix_seconds),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    rtc_fields_to_unix_seconds_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_raw_second   (i_raw_second),
        .i_raw_minute   (i_raw_minute),
        .i_raw_hour     (i_raw_hour),
        .i_raw_day      (i_raw_day),
        .i_raw_month    (i_raw_month),
        .i_raw_year     (i_raw_year),
        .i_raw_century  (i_raw_century),
        .i_status_b     (i_status_b),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_unix_seconds (o_unix_seconds),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    // receiver back-pressure, one fresh decision per cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic logic [7:0] encode_field(input int v, input logic binary);
        if (binary) begin
            return 8'(v);
        end
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    // mostly plausible clock readings in the mode status b selects, the rest raw noise
    function automatic logic [63:0] random_snapshot();
        logic [7:0] sb;
        logic [7:0] hour_b;
        logic       pm;
        int         hour;
        sb = 8'($urandom);
        if ($urandom_range(0, 9) < 4) begin
            return {$urandom, $urandom};
        end
        if (sb[rfu_pkg::SB_24HOUR]) begin
            hour = $urandom_range(0, 23);
            pm   = 1'b0;
        end else begin
            hour = $urandom_range(1, 12);
            pm   = 1'($urandom_range(0, 1));
        end
        hour_b = encode_field(hour, sb[rfu_pkg::SB_BINARY]) | (8'(pm) << rfu_pkg::HOUR_PM);
        return {encode_field($urandom_range(0, 59), sb[rfu_pkg::SB_BINARY]),
                encode_field($urandom_range(0, 59), sb[rfu_pkg::SB_BINARY]),
                hour_b,
                encode_field($urandom_range(1, 31), sb[rfu_pkg::SB_BINARY]),
                encode_field($urandom_range(1, 12), sb[rfu_pkg::SB_BINARY]),
                encode_field($urandom_range(0, 99), sb[rfu_pkg::SB_BINARY]),
                encode_field($urandom_range(19, 21), sb[rfu_pkg::SB_BINARY]),
                sb};
    endfunction

    // present one snapshot and hold it until taken; valid stays high on return so a
    // back-to-back item never drops it
    task automatic send_snapshot(input logic [63:0] snap);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        {i_raw_second, i_raw_minute, i_raw_hour, i_raw_day, i_raw_month,
         i_raw_year, i_raw_century, i_status_b} <= snap;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // hold off the sender until every expected result has come back
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    // write both registers back to back, only while the pipeline is empty
    task automatic apply_settings(input logic use_century,
                                  input logic [rfu_pkg::BASE_YEAR_W-1:0] year);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= rfu_pkg::CFG_CENTURY_PRESENT;
        // upper data bits are don't-care for this register
        i_cfg_data  <= {13'($urandom), use_century};
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_index <= rfu_pkg::CFG_BASE_YEAR;
        i_cfg_data  <= year;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic                            use_century;
        logic [rfu_pkg::BASE_YEAR_W-1:0] year;

        // every block input known from time zero
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_raw_second   <= '0;
        i_raw_minute   <= '0;
        i_raw_hour     <= '0;
        i_raw_day      <= '0;
        i_raw_month    <= '0;
        i_raw_year     <= '0;
        i_raw_century  <= '0;
        i_status_b     <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= rfu_pkg::CFG_CENTURY_PRESENT;
        i_cfg_data     <= '0;
        send_gap_pct   = 18;
        recv_stall_pct = 49;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, first on the reset settings, then with the century byte
        foreach (snapshots_reset_cfg[k]) begin
            send_snapshot(snapshots_reset_cfg[k]);
        end
        drain_pipeline();
        apply_settings(1'b1, rfu_pkg::BASE_YEAR_RST);
        foreach (snapshots_century[k]) begin
            send_snapshot(snapshots_century[k]);
        end

        // random part: each phase drains, picks new settings and idling, then streams
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_pipeline();
            if (phase < 3) begin
                send_gap_pct   = 18;
                recv_stall_pct = 49;
            end else if (phase < 6) begin
                send_gap_pct   = 49;
                recv_stall_pct = 18;
            end else begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            case (phase)
                0:       begin use_century = 1'b0; year = '0;                      end
                1:       begin use_century = 1'b1; year = 14'($urandom);           end
                2:       begin use_century = 1'b0; year = '1;                      end
                3:       begin use_century = 1'b0; year = 14'd1970;                end
                4:       begin use_century = 1'b1; year = 14'd9999;                end
                5:       begin use_century = 1'b0; year = 14'($urandom);           end
                6:       begin use_century = 1'b0; year = 14'($urandom_range(1970, 9999)); end
                default: begin use_century = 1'b1; year = '0;                      end
            endcase
            apply_settings(use_century, year);
            repeat (ITEMS_PER_PHASE) begin
                send_snapshot(random_snapshot());
            end
        end

        // wait out the last results plus a margin over the six-stage latency
        drain_pipeline();
        repeat (12) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(WATCHDOG_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/rfu_pkg.sv
rtl/rtc_fields_to_unix_seconds.sv
dv/rtc_fields_to_unix_seconds_checker.sv
dv/rtc_fields_to_unix_seconds_tb.sv
